[sv/cbd_pkg.sv]
// Shared types, codes and character helpers for the chunked body decoder.
`default_nettype none

package cbd_pkg;

  typedef enum logic [4:0] {
    PH_SIZE        = 5'b00001,
    PH_DATA        = 5'b00010,
    PH_SKIP_FIRST  = 5'b00100,
    PH_SKIP_SECOND = 5'b01000,
    PH_DONE        = 5'b10000
  } phase_t;

  localparam logic [2:0] CAUSE_NONE      = 3'd0;
  localparam logic [2:0] CAUSE_ZERO      = 3'd1;
  localparam logic [2:0] CAUSE_INPUT_END = 3'd2;
  localparam logic [2:0] CAUSE_NO_DIGITS = 3'd3;
  localparam logic [2:0] CAUSE_OVERFLOW  = 3'd4;
  localparam logic [2:0] CAUSE_TRUNCATED = 3'd5;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic CFG_IDX_PASS_THROUGH = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       end_flag;
    logic [2:0] end_cause;
  } result_t;

  // Bit 4 is set when the character is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

`default_nettype wire

[sv/cbd_cfg.sv]
// Configuration register file on the APB-style port.
`default_nettype none

module cbd_cfg import cbd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic             pass_through
);

  logic sel_pass_through;

  assign sel_pass_through = (paddr[2] == CFG_IDX_PASS_THROUGH);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_through <= 1'b0;
    end else if (psel && penable && pwrite && pready && sel_pass_through) begin
      pass_through <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (sel_pass_through) begin
      prdata = {31'd0, pass_through};
    end
  end

endmodule

`default_nettype wire

[sv/cbd_in_stage.sv]
// Input register that holds one accepted beat until the decoder consumes it.
`default_nettype none

module cbd_in_stage import cbd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       advance,
  output logic            in_ready,
  output logic            valid,
  output in_item_t        item
);

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.in_byte <= in_byte;
      item.in_last <= in_last;
    end
  end

endmodule

`default_nettype wire

[sv/cbd_core.sv]
// Decoder state and the per-beat next-state and result logic.
`default_nettype none

module cbd_core import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     advance,
  input  wire in_item_t item,
  input  wire logic     pass_through,
  output logic          emit,
  output result_t       res
);

  phase_t               phase, phase_next;
  logic [SIZE_BITS-1:0] size_accumulator, size_accumulator_next;
  logic                 digits_seen, digits_seen_next;
  logic                 digits_stopped, digits_stopped_next;
  logic                 previous_was_cr, previous_was_cr_next;
  logic [SIZE_BITS-1:0] bytes_remaining, bytes_remaining_next;

  always_comb begin
    logic [7:0]           b;
    logic                 last;
    logic [4:0]           h;
    logic [SIZE_BITS-1:0] rem_dec;
    logic                 do_finish;
    logic                 fin_valid;
    logic [2:0]           fin_cause;
    logic                 do_rearm;

    b         = item.in_byte;
    last      = item.in_last;
    h         = hex_value(b);
    rem_dec   = (bytes_remaining != '0) ? bytes_remaining - 1'b1 : bytes_remaining;
    do_finish = 1'b0;
    fin_valid = 1'b0;
    fin_cause = CAUSE_NONE;
    do_rearm  = 1'b0;

    phase_next            = phase;
    size_accumulator_next = size_accumulator;
    digits_seen_next      = digits_seen;
    digits_stopped_next   = digits_stopped;
    previous_was_cr_next  = previous_was_cr;
    bytes_remaining_next  = bytes_remaining;
    emit = 1'b0;
    res  = '0;

    if (pass_through) begin
      emit             = 1'b1;
      res.payload_byte = b;
      res.byte_valid   = 1'b1;
      if (last) begin
        res.end_flag  = 1'b1;
        res.end_cause = CAUSE_INPUT_END;
        do_rearm      = 1'b1;
      end
    end else begin
      case (phase)
        PH_SIZE: begin
          if (b == CHAR_LF && previous_was_cr) begin
            if (!digits_seen) begin
              do_finish = 1'b1;
              fin_cause = CAUSE_NO_DIGITS;
            end else if (size_accumulator == '0) begin
              do_finish = 1'b1;
              fin_cause = CAUSE_ZERO;
            end else if (last) begin
              do_finish = 1'b1;
              fin_cause = CAUSE_TRUNCATED;
            end else begin
              bytes_remaining_next = size_accumulator;
              phase_next           = PH_DATA;
              previous_was_cr_next = 1'b0;
            end
          end else begin
            previous_was_cr_next = (b == CHAR_CR);
            if (!digits_stopped) begin
              if (h[4]) begin
                if (size_accumulator[SIZE_BITS-1 -: 4] != 4'd0) begin
                  do_finish = 1'b1;
                  fin_cause = CAUSE_OVERFLOW;
                end else begin
                  size_accumulator_next = {size_accumulator[SIZE_BITS-5:0], h[3:0]};
                  digits_seen_next      = 1'b1;
                end
              end else if (digits_seen || !is_blank(b)) begin
                digits_stopped_next = 1'b1;
              end
            end
            if (!do_finish && last) begin
              do_finish = 1'b1;
              fin_cause = CAUSE_INPUT_END;
            end
          end
        end
        PH_DATA: begin
          bytes_remaining_next = rem_dec;
          emit             = 1'b1;
          res.payload_byte = b;
          res.byte_valid   = 1'b1;
          if (rem_dec == '0) begin
            if (last) begin
              do_finish = 1'b1;
              fin_valid = 1'b1;
              fin_cause = CAUSE_INPUT_END;
            end else begin
              phase_next = PH_SKIP_FIRST;
            end
          end else if (last) begin
            do_finish = 1'b1;
            fin_valid = 1'b1;
            fin_cause = CAUSE_TRUNCATED;
          end
        end
        PH_SKIP_FIRST: begin
          if (last) begin
            do_finish = 1'b1;
            fin_cause = CAUSE_INPUT_END;
          end else begin
            phase_next = PH_SKIP_SECOND;
          end
        end
        PH_SKIP_SECOND: begin
          if (last) begin
            do_finish = 1'b1;
            fin_cause = CAUSE_INPUT_END;
          end else begin
            do_rearm = 1'b1;
          end
        end
        PH_DONE: begin
          do_rearm = last;
        end
        default: begin
          do_rearm = 1'b1;
        end
      endcase

      if (do_finish) begin
        emit             = 1'b1;
        res.payload_byte = fin_valid ? b : 8'd0;
        res.byte_valid   = fin_valid;
        res.end_flag     = 1'b1;
        res.end_cause    = fin_cause;
        if (last) begin
          do_rearm = 1'b1;
        end else begin
          phase_next = PH_DONE;
        end
      end
    end

    if (do_rearm) begin
      phase_next            = PH_SIZE;
      size_accumulator_next = '0;
      digits_seen_next      = 1'b0;
      digits_stopped_next   = 1'b0;
      previous_was_cr_next  = 1'b0;
      bytes_remaining_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SIZE;
      size_accumulator <= '0;
      digits_seen      <= 1'b0;
      digits_stopped   <= 1'b0;
      previous_was_cr  <= 1'b0;
      bytes_remaining  <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      size_accumulator <= size_accumulator_next;
      digits_seen      <= digits_seen_next;
      digits_stopped   <= digits_stopped_next;
      previous_was_cr  <= previous_was_cr_next;
      bytes_remaining  <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

[sv/cbd_out_stage.sv]
// Result register that presents one beat on the output channel.
`default_nettype none

module cbd_out_stage import cbd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  input  wire logic    out_ready,
  output logic         out_valid,
  output logic         free,
  output result_t      out_res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

[sv/chunked_body_decoder_unit.sv]
// Top level of the chunked body decoder.
// A beat waits in the input register until the result register is free; its result, if any,
// is loaded there. Throughput: one beat per cycle unless the output stalls; the input register
// and the result register decouple the two channels; the decoder state updates once per beat.
// Reset: synchronous and active high; it empties both registers, returns the decoder to the
// start of a size line and clears pass-through mode.
`default_nettype none

module chunked_body_decoder_unit import cbd_pkg::*; #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       payload_byte,
  output logic             byte_valid,
  output logic             end_flag,
  output logic [2:0]       end_cause
);

  logic     pass_through;
  logic     s1_valid;
  in_item_t s1_item;
  logic     out_free;
  logic     advance;
  logic     emit;
  result_t  core_res;
  result_t  out_res;

  assign advance = s1_valid && out_free;

  cbd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pass_through (pass_through)
  );

  cbd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .advance  (advance),
    .in_ready (in_ready),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  cbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (s1_item),
    .pass_through (pass_through),
    .emit         (emit),
    .res          (core_res)
  );

  cbd_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .res       (core_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .out_res   (out_res)
  );

  assign payload_byte = out_res.payload_byte;
  assign byte_valid   = out_res.byte_valid;
  assign end_flag     = out_res.end_flag;
  assign end_cause    = out_res.end_cause;

endmodule

`default_nettype wire
